// ===== src/bctl_pkg.sv =====
package bctl_pkg;

  localparam int unsigned NUM_ENTRIES_DEFAULT = 32;

  localparam logic [2:0] MODE_GET        = 3'd0;
  localparam logic [2:0] MODE_RELEASE    = 3'd1;
  localparam logic [2:0] MODE_PIN        = 3'd2;
  localparam logic [2:0] MODE_UNPIN      = 3'd3;
  localparam logic [2:0] MODE_MARK_VALID = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // one entry word: tag, valid, count, stamp
  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] block_number;
    logic        valid;
    logic [7:0]  count;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [4:0] result_index;
    logic       hit;
    logic       needs_read;
    logic [1:0] status;
  } rsp_t;

endpackage

// ===== src/bctl_if.sv =====
interface bctl_req_if;
  logic         valid;
  logic         ready;
  bctl_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bctl_rsp_if;
  logic         valid;
  logic         ready;
  bctl_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/bctl_ram.sv =====
module bctl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/block_cache_tag_lru.sv =====
// A get makes one scan of the entry RAM, one word a cycle through its single read port,
//   and then writes back.
// Other modes read, then modify; the write back overlaps the result cycle.
// Requests: one at a time, the next taken once the result has been accepted.
// Reset: synchronous; afterwards a clearing pass writes every RAM entry to zero,
//   during which no request is taken. Stamp clock resets to 1.
module block_cache_tag_lru #(
  parameter int unsigned NUM_ENTRIES = bctl_pkg::NUM_ENTRIES_DEFAULT
) (
  input logic clk,
  input logic rst,
  bctl_req_if.sink   req,
  bctl_rsp_if.source rsp
);
  localparam int unsigned AW = $clog2(NUM_ENTRIES);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_RMW   = 6'b001000,
    S_WRITE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  bctl_pkg::req_t  cur;
  bctl_pkg::rsp_t  res;
  logic [AW:0]     cnt;       // scan issue counter
  logic [AW:0]     seen;      // words received
  logic            found_hit, found_free;
  logic [AW-1:0]   hit_idx, free_idx;
  logic [31:0]     oldest;
  bctl_pkg::entry_t hit_word;
  logic [31:0]     stamp_clock;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  bctl_pkg::entry_t wdata, rdata;
  logic             rd_pend;

  logic             we_next;
  logic [AW-1:0]    waddr_next;
  bctl_pkg::entry_t wdata_next;
  bctl_pkg::rsp_t   res_next;
  logic             stamp_take;

  bctl_ram #(.WIDTH(bctl_pkg::ENTRY_W), .DEPTH(NUM_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // hold off while the last clearing write is still pending
  assign req.ready   = (state == S_IDLE) && !we;
  assign rsp.valid   = (state == S_OUT);
  assign rsp.payload = res;

  logic idx_ok;
  assign idx_ok = ({27'd0, cur.entry_index} < 32'(NUM_ENTRIES));

  // read address: scan counter in get, addressed entry otherwise
  always_comb begin
    if (state == S_SCAN) raddr = cnt[AW-1:0];
    else raddr = AW'(req.payload.entry_index);
  end

  logic match;
  assign match = rdata.device == cur.device && rdata.block_number == cur.block_number;

  // build the write back word and the result
  always_comb begin
    we_next = 1'b0;
    waddr_next = waddr;
    wdata_next = wdata;
    res_next = res;
    stamp_take = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we_next = 1'b1;
        waddr_next = cnt[AW-1:0];
        wdata_next = '0;
      end
      S_WRITE: begin
        res_next.hit = 1'b0;
        res_next.status = bctl_pkg::ST_OK;
        if (found_hit) begin
          res_next.result_index = 5'(hit_idx);
          res_next.hit = 1'b1;
          res_next.needs_read = !hit_word.valid;
          waddr_next = hit_idx;
          wdata_next = hit_word;
          if (hit_word.count == bctl_pkg::COUNT_MAX) begin
            res_next.status = bctl_pkg::ST_SATURATED;
          end else begin
            we_next = 1'b1;
            wdata_next.count = hit_word.count + 8'd1;
          end
        end else if (found_free) begin
          res_next.result_index = 5'(free_idx);
          res_next.needs_read = 1'b1;
          we_next = 1'b1;
          waddr_next = free_idx;
          wdata_next = '{device: cur.device, block_number: cur.block_number,
                         valid: 1'b0, count: 8'd1, stamp: oldest};
        end else begin
          res_next.result_index = '0;
          res_next.needs_read = 1'b0;
          res_next.status = bctl_pkg::ST_NO_FREE;
        end
      end
      S_RMW: begin
        // word of the addressed entry is in rdata now
        res_next.result_index = cur.entry_index;
        res_next.hit = 1'b0;
        res_next.status = bctl_pkg::ST_OK;
        res_next.needs_read = idx_ok && !rdata.valid;
        waddr_next = AW'(cur.entry_index);
        wdata_next = rdata;
        if (idx_ok) begin
          unique case (cur.mode)
            bctl_pkg::MODE_RELEASE, bctl_pkg::MODE_UNPIN: begin
              if (rdata.count == 8'd0) res_next.status = bctl_pkg::ST_UNDERFLOW;
              else begin
                we_next = 1'b1;
                wdata_next.count = rdata.count - 8'd1;
                if (rdata.count == 8'd1) begin
                  wdata_next.stamp = stamp_clock;
                  stamp_take = 1'b1;
                end
              end
            end
            bctl_pkg::MODE_PIN: begin
              if (rdata.count == bctl_pkg::COUNT_MAX) begin
                res_next.status = bctl_pkg::ST_SATURATED;
              end else begin
                we_next = 1'b1;
                wdata_next.count = rdata.count + 8'd1;
              end
            end
            bctl_pkg::MODE_MARK_VALID: begin
              we_next = 1'b1;
              wdata_next.valid = 1'b1;
              res_next.needs_read = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // register the write port and the result
  always_ff @(posedge clk) begin
    waddr <= waddr_next;
    wdata <= wdata_next;
    res <= res_next;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      stamp_clock <= 32'd1;
      we <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      we <= we_next;
      if (stamp_take) stamp_clock <= stamp_clock + 32'd1;
      unique case (state)
        S_CLEAR: begin
          if (cnt == (AW+1)'(NUM_ENTRIES - 1)) begin
            state <= S_IDLE;
            cnt <= '0;
          end else cnt <= cnt + (AW+1)'(1);
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.payload;
            cnt <= '0;
            seen <= '0;
            found_hit <= 1'b0;
            found_free <= 1'b0;
            rd_pend <= 1'b0;
            state <= (req.payload.mode == bctl_pkg::MODE_GET) ? S_SCAN : S_RMW;
          end
        end
        S_SCAN: begin
          // issue one read a cycle, take the word from the previous one
          if (cnt < (AW+1)'(NUM_ENTRIES)) cnt <= cnt + (AW+1)'(1);
          rd_pend <= (cnt < (AW+1)'(NUM_ENTRIES));
          if (rd_pend) begin
            seen <= seen + (AW+1)'(1);
            if (match && !found_hit) begin
              found_hit <= 1'b1;
              hit_idx <= seen[AW-1:0];
              hit_word <= rdata;
            end
            if (rdata.count == 8'd0 && (!found_free || rdata.stamp < oldest)) begin
              found_free <= 1'b1;
              free_idx <= seen[AW-1:0];
              oldest <= rdata.stamp;
            end
            if (seen == (AW+1)'(NUM_ENTRIES - 1)) state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_OUT;
        end
        S_RMW: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // no request taken while clearing
  assert property (@(posedge clk) disable iff (rst) state == S_CLEAR |-> !req.ready)
    else $error("ready during clear");
  // result shown only after a request was taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_WRITE || state == S_RMW))
    else $error("result without request");
  // hit only reported for get
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.hit |-> cur.mode == bctl_pkg::MODE_GET)
    else $error("hit on non-get");
endmodule
